/* hw/rtl/brz_pkg.sv */
`default_nettype none
package brz_pkg;

  // Frame store geometry and pixel width
  localparam int unsigned MAX_SRC_WIDTH  = 256;
  localparam int unsigned MAX_SRC_HEIGHT = 256;
  localparam int unsigned MAX_OUT_DIM    = 4096;
  localparam int unsigned PIXEL_BITS     = 16;

  localparam int unsigned STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int unsigned SIDX_W = 8;   // source row / column index
  localparam int unsigned OIDX_W = 12;  // output row / column
  localparam int unsigned SDIM_W = 9;   // source size registers
  localparam int unsigned TDIM_W = 13;  // target size registers
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned WGT_W  = 12;  // axis weights and denominators

  // Datapath widths
  localparam int unsigned NUMA_W = OIDX_W + SIDX_W;  // axis numerator
  localparam int unsigned TOP_W  = PIX_W + WGT_W + 1;
  localparam int unsigned PROD_W = TOP_W + WGT_W;
  localparam int unsigned ACC_W  = PROD_W + 1;
  localparam int unsigned DIV_W  = ACC_W + 2;
  localparam int unsigned CNT_W  = 5;

  // Divider step counts
  localparam int unsigned AXIS_STEPS  = SIDX_W;
  localparam int unsigned FINAL_STEPS = PIX_W;

  // Multiply-accumulate schedule length
  localparam int unsigned MAC_STEPS = 7;
  localparam int unsigned RD_STEPS  = 4;

  typedef struct packed {
    logic [SDIM_W-1:0] src_w;
    logic [SDIM_W-1:0] src_h;
    logic [TDIM_W-1:0] tgt_w;
    logic [TDIM_W-1:0] tgt_h;
    logic              wide;
  } cfg_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_LOAD,
    CMD_DIV_STEP,
    CMD_Y_DONE,
    CMD_X_DONE,
    CMD_READ,
    CMD_MUL,
    CMD_FDIV_LOAD,
    CMD_OUT
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e          op;
    logic [CNT_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
  } dp_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVY,
    ST_DIVX,
    ST_READ,
    ST_MUL,
    ST_FDIV,
    ST_FIN
  } state_e;

endpackage
`default_nettype wire

/* hw/rtl/bilinear_image_resize.sv */
`default_nettype none
// Channel  | Handshake               | Beat contents
// ---------+-------------------------+----------------------------------------------
// in       | in_valid_i / in_ready_o | operation, src_row, src_col, pixel_value,
//          |                         | out_row, out_col
// out      | out_valid_o/out_ready_i | result_pixel, status
// config   | APB psel/penable/pwrite | source/target size, wide_pixels
//
// A write beat leaves the input ready. A compute beat runs two
// 8-step axis divisions and a 16-step rounding division on one shared divider,
// four reads on the single frame store port, and seven steps on one multiplier.
// An out-of-range coordinate skips the divider, reads and multiplier. The output
// register lets a new beat enter while a result waits. Reset clears control
// only; the frame store is not cleared and holds garbage until written.
module bilinear_image_resize
  import brz_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              operation_i,
  input  wire logic [SIDX_W-1:0] src_row_i,
  input  wire logic [SIDX_W-1:0] src_col_i,
  input  wire logic [PIX_W-1:0]  pixel_value_i,
  input  wire logic [OIDX_W-1:0] out_row_i,
  input  wire logic [OIDX_W-1:0] out_col_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [PIX_W-1:0]  result_pixel_o,
  output logic                   status_o
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  brz_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  brz_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  brz_dp u_dp (
    .clk_i          (clk_i),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .src_row_i      (src_row_i),
    .src_col_i      (src_col_i),
    .pixel_value_i  (pixel_value_i),
    .out_row_i      (out_row_i),
    .out_col_i      (out_col_i),
    .result_pixel_o (result_pixel_o),
    .status_o       (status_o)
  );

endmodule
`default_nettype wire

/* hw/rtl/brz_regs.sv */
`default_nettype none
module brz_regs
  import brz_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  localparam logic [2:0] REG_SRC_W = 3'd0;
  localparam logic [2:0] REG_SRC_H = 3'd1;
  localparam logic [2:0] REG_TGT_W = 3'd2;
  localparam logic [2:0] REG_TGT_H = 3'd3;
  localparam logic [2:0] REG_WIDE  = 3'd4;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_w <= SDIM_W'(256);
      cfg_q.src_h <= SDIM_W'(256);
      cfg_q.tgt_w <= TDIM_W'(256);
      cfg_q.tgt_h <= TDIM_W'(256);
      cfg_q.wide  <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_SRC_W: cfg_q.src_w <= pwdata[SDIM_W-1:0];
        REG_SRC_H: cfg_q.src_h <= pwdata[SDIM_W-1:0];
        REG_TGT_W: cfg_q.tgt_w <= pwdata[TDIM_W-1:0];
        REG_TGT_H: cfg_q.tgt_h <= pwdata[TDIM_W-1:0];
        REG_WIDE:  cfg_q.wide  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (paddr[4:2])
      REG_SRC_W: prdata = 32'(cfg_q.src_w);
      REG_SRC_H: prdata = 32'(cfg_q.src_h);
      REG_TGT_W: prdata = 32'(cfg_q.tgt_w);
      REG_TGT_H: prdata = 32'(cfg_q.tgt_h);
      REG_WIDE:  prdata = 32'(cfg_q.wide);
      default:   prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/brz_ctrl.sv */
`default_nettype none
module brz_ctrl
  import brz_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     operation_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  dp_stat_t      stat_i,
  output dp_cmd_t       cmd_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept, out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept && operation_i) state_d = ST_DIVY;
      end
      ST_DIVY: begin
        if (cnt_q == '0 && stat_i.err) begin
          state_d = ST_FIN;
        end else if (cnt_q == CNT_W'(AXIS_STEPS)) begin
          state_d = ST_DIVX;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIVX: begin
        if (cnt_q == CNT_W'(AXIS_STEPS)) begin
          state_d = ST_READ;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_READ: begin
        if (cnt_q == CNT_W'(RD_STEPS)) begin
          state_d = ST_MUL;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MUL: begin
        if (cnt_q == CNT_W'(MAC_STEPS - 1)) begin
          state_d = ST_FDIV;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FDIV: begin
        if (cnt_q == CNT_W'(FINAL_STEPS)) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands and output valid
  always_comb begin
    cmd_o.op    = CMD_NONE;
    cmd_o.idx   = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) cmd_o.op = operation_i ? CMD_LOAD : CMD_WRITE;
      end
      ST_DIVY: begin
        if (cnt_q == CNT_W'(AXIS_STEPS))  cmd_o.op = CMD_Y_DONE;
        else if (!(cnt_q == '0 && stat_i.err)) cmd_o.op = CMD_DIV_STEP;
      end
      ST_DIVX: cmd_o.op = (cnt_q == CNT_W'(AXIS_STEPS)) ? CMD_X_DONE : CMD_DIV_STEP;
      ST_READ: cmd_o.op = CMD_READ;
      ST_MUL:  cmd_o.op = CMD_MUL;
      ST_FDIV: cmd_o.op = (cnt_q == '0) ? CMD_FDIV_LOAD : CMD_DIV_STEP;
      ST_FIN: begin
        if (out_free) begin
          cmd_o.op    = CMD_OUT;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/brz_dp.sv */
`default_nettype none
module brz_dp
  import brz_pkg::*;
(
  input  wire logic              clk_i,
  input  cfg_t                   cfg_i,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  input  wire logic [SIDX_W-1:0] src_row_i,
  input  wire logic [SIDX_W-1:0] src_col_i,
  input  wire logic [PIX_W-1:0]  pixel_value_i,
  input  wire logic [OIDX_W-1:0] out_row_i,
  input  wire logic [OIDX_W-1:0] out_col_i,
  output logic      [PIX_W-1:0]  result_pixel_o,
  output logic                   status_o
);

  logic [PIX_W-1:0] mem [STORE_DEPTH];
  logic [PIX_W-1:0] rdata_q;

  logic [SIDX_W-1:0] smw_q, smh_q, y0_q, y1_q, x0_q, x1_q;
  logic [WGT_W-1:0]  dx_q, dy_q, rx_q, ry_q;
  logic [NUMA_W-1:0] numx_q;
  logic              err_q;
  logic [PIX_W-1:0]  pix_q [RD_STEPS];
  logic [PROD_W-1:0] prod_q;
  logic [TOP_W-1:0]  top_q, bot_q;
  logic [ACC_W-1:0]  acc_q;
  logic [DIV_W-1:0]  rem_q, dvs_q;
  logic [PIX_W-1:0]  quo_q;
  logic [PIX_W-1:0]  res_q;
  logic              stat_q;

  // Item decode for a compute beat
  logic [SDIM_W-1:0] swc, shc;
  logic [TDIM_W-1:0] twc, thc;
  logic [SIDX_W-1:0] smw, smh;
  logic [WGT_W-1:0]  dx, dy;
  logic              err;
  logic [NUMA_W-1:0] numy, numx;

  always_comb begin
    swc = (cfg_i.src_w == '0) ? SDIM_W'(1) :
          (cfg_i.src_w > SDIM_W'(MAX_SRC_WIDTH)) ? SDIM_W'(MAX_SRC_WIDTH) : cfg_i.src_w;
    shc = (cfg_i.src_h == '0) ? SDIM_W'(1) :
          (cfg_i.src_h > SDIM_W'(MAX_SRC_HEIGHT)) ? SDIM_W'(MAX_SRC_HEIGHT) : cfg_i.src_h;
    twc = (cfg_i.tgt_w > TDIM_W'(MAX_OUT_DIM)) ? TDIM_W'(MAX_OUT_DIM) : cfg_i.tgt_w;
    thc = (cfg_i.tgt_h > TDIM_W'(MAX_OUT_DIM)) ? TDIM_W'(MAX_OUT_DIM) : cfg_i.tgt_h;
    smw = SIDX_W'(swc - 1'b1);
    smh = SIDX_W'(shc - 1'b1);
    // a single-column target maps everything to zero; a unit divisor does that
    dx  = (twc <= TDIM_W'(1)) ? WGT_W'(1) : WGT_W'(twc - 1'b1);
    dy  = (thc <= TDIM_W'(1)) ? WGT_W'(1) : WGT_W'(thc - 1'b1);
    err = (TDIM_W'(out_col_i) >= twc) | (TDIM_W'(out_row_i) >= thc);
    numx = NUMA_W'(out_col_i) * NUMA_W'(smw);
    numy = NUMA_W'(out_row_i) * NUMA_W'(smh);
  end

  assign stat_o.err = err_q;

  // Shared restoring divider step
  logic             ge;
  logic [SIDX_W-1:0] qax, lo, hi;
  logic [SIDX_W-1:0] smax;

  assign ge   = (rem_q >= dvs_q);
  assign qax  = quo_q[SIDX_W-1:0];
  assign smax = (cmd_i.op == CMD_Y_DONE) ? smh_q : smw_q;
  assign lo   = (qax > smax) ? smax : qax;
  assign hi   = (lo < smax) ? lo + 1'b1 : smax;

  // Frame store read and write addresses and write enable
  logic [ADDR_W-1:0] raddr, waddr;
  logic [SIDX_W-1:0] ry_sel, rx_sel;
  logic              we;

  always_comb begin
    ry_sel = cmd_i.idx[1] ? y1_q : y0_q;
    rx_sel = cmd_i.idx[0] ? x1_q : x0_q;
    raddr  = ADDR_W'(ry_sel) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(rx_sel);
    waddr  = ADDR_W'(src_row_i) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(src_col_i);
    we     = (cmd_i.op == CMD_WRITE) &&
             (32'(src_row_i) < MAX_SRC_HEIGHT) && (32'(src_col_i) < MAX_SRC_WIDTH);
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= pixel_value_i;
    else    rdata_q    <= mem[raddr];
  end

  // Pixel width mask on read
  logic [PIX_W-1:0] pix_m;
  assign pix_m = cfg_i.wide ? (rdata_q & PIX_W'((32'd1 << PIXEL_BITS) - 1))
                            : (rdata_q & PIX_W'(8'hFF));

  // Shared multiplier operands
  logic [TOP_W-1:0] mul_a;
  logic [WGT_W-1:0] mul_b;
  logic [WGT_W-1:0] wx0, wy0;

  assign wx0 = dx_q - rx_q;
  assign wy0 = dy_q - ry_q;

  always_comb begin
    case (cmd_i.idx[2:0])
      3'd0:    begin mul_a = TOP_W'(pix_q[0]); mul_b = wx0;  end
      3'd1:    begin mul_a = TOP_W'(pix_q[1]); mul_b = rx_q; end
      3'd2:    begin mul_a = TOP_W'(pix_q[2]); mul_b = wx0;  end
      3'd3:    begin mul_a = TOP_W'(pix_q[3]); mul_b = rx_q; end
      3'd4:    begin mul_a = top_q;            mul_b = wy0;  end
      3'd5:    begin mul_a = bot_q;            mul_b = ry_q; end
      default: begin mul_a = TOP_W'(dx_q);     mul_b = dy_q; end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        smw_q  <= smw;
        smh_q  <= smh;
        dx_q   <= dx;
        dy_q   <= dy;
        err_q  <= err;
        numx_q <= numx;
        rem_q  <= DIV_W'(numy);
        dvs_q  <= DIV_W'(dy) << (AXIS_STEPS - 1);
        quo_q  <= '0;
      end
      CMD_DIV_STEP: begin
        if (ge) rem_q <= rem_q - dvs_q;
        dvs_q <= dvs_q >> 1;
        quo_q <= {quo_q[PIX_W-2:0], ge};
      end
      CMD_Y_DONE: begin
        y0_q  <= lo;
        y1_q  <= hi;
        ry_q  <= rem_q[WGT_W-1:0];
        rem_q <= DIV_W'(numx_q);
        dvs_q <= DIV_W'(dx_q) << (AXIS_STEPS - 1);
        quo_q <= '0;
      end
      CMD_X_DONE: begin
        x0_q <= lo;
        x1_q <= hi;
        rx_q <= rem_q[WGT_W-1:0];
      end
      CMD_READ: begin
        if (cmd_i.idx != '0) pix_q[cmd_i.idx[1:0] - 2'd1] <= pix_m;
      end
      CMD_MUL: begin
        prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
        case (cmd_i.idx[2:0])
          3'd1:    top_q <= TOP_W'(prod_q);
          3'd2:    top_q <= top_q + TOP_W'(prod_q);
          3'd3:    bot_q <= TOP_W'(prod_q);
          3'd4:    bot_q <= bot_q + TOP_W'(prod_q);
          3'd5:    acc_q <= ACC_W'(prod_q);
          3'd6:    acc_q <= acc_q + ACC_W'(prod_q);
          default: ;
        endcase
      end
      CMD_FDIV_LOAD: begin
        // round half up: (2*num + den) / (2*den)
        rem_q <= (DIV_W'(acc_q) << 1) + DIV_W'(prod_q);
        dvs_q <= DIV_W'(prod_q) << FINAL_STEPS;
        quo_q <= '0;
      end
      CMD_OUT: begin
        res_q  <= err_q ? '0 : quo_q;
        stat_q <= err_q;
      end
      default: ;
    endcase
  end

  assign result_pixel_o = res_q;
  assign status_o       = stat_q;

endmodule
`default_nettype wire

/* hw/rtl/brz_checker.sv */
`default_nettype none
module brz_checker
  import brz_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              pready,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              operation_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [PIX_W-1:0]  result_pixel_o,
  input wire logic              status_o
);

  // Result beat holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_pixel_o))
    else $error("result beat dropped or changed while stalled");

  // A compute beat occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i |=> !in_ready_o)
    else $error("input taken while a compute beat is in flight");

  // A write beat leaves the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !operation_i |=> in_ready_o)
    else $error("write beat stalled the input");

  // Error results carry a zero pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> result_pixel_o == '0)
    else $error("error result with nonzero pixel");

  // Register port never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind bilinear_image_resize brz_checker u_brz_checker (.*);
`default_nettype wire

/* bench/resize_monitor.sv */
// Watches the config port and both channels, predicts every result of the
// resizer and compares it with what comes out.
module resize_monitor
  import brz_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              operation_i,
  input  logic [SIDX_W-1:0] src_row_i,
  input  logic [SIDX_W-1:0] src_col_i,
  input  logic [PIX_W-1:0]  pixel_value_i,
  input  logic [OIDX_W-1:0] out_row_i,
  input  logic [OIDX_W-1:0] out_col_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [PIX_W-1:0]  result_pixel_i,
  input  logic              status_i,
  output int                fail_count_o,
  output int                pending_o
);

  // Register indexes (byte address / 4)
  localparam int unsigned IDX_SRC_W = 0;
  localparam int unsigned IDX_SRC_H = 1;
  localparam int unsigned IDX_TGT_W = 2;
  localparam int unsigned IDX_TGT_H = 3;
  localparam int unsigned IDX_WIDE  = 4;

  localparam logic OP_WRITE = 1'b0;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             status;
  } resized_pixel_t;

  resized_pixel_t    expected_pixels[$];
  logic [PIX_W-1:0]  frame_copy [STORE_DEPTH];
  logic [SDIM_W-1:0] src_w, src_h;
  logic [TDIM_W-1:0] tgt_w, tgt_h;
  logic              wide;
  int                mismatches;

  function automatic longint unsigned stored_pixel(int unsigned row, int unsigned col);
    longint unsigned mask;
    mask = wide ? ((64'd1 << PIXEL_BITS) - 1) : 64'hFF;
    return longint'(frame_copy[row * MAX_SRC_WIDTH + col]) & mask;
  endfunction

  // Align-corners mapping of one axis: lower/upper index and weight rem/den
  function automatic void map_coord(input int unsigned o, input int unsigned src,
                                    input int unsigned dst, output int unsigned lo,
                                    output int unsigned hi, output longint unsigned rem,
                                    output longint unsigned den);
    longint unsigned num;
    if (dst <= 1) begin
      lo  = 0;
      den = 1;
      rem = 0;
    end else begin
      num = longint'(o) * longint'(src - 1);
      den = dst - 1;
      lo  = int'(num / den);
      rem = num % den;
    end
    if (lo > src - 1) lo = src - 1;
    hi = (lo + 1 < src) ? lo + 1 : src - 1;
  endfunction

  function automatic resized_pixel_t blend_pixel(int unsigned orow, int unsigned ocol);
    resized_pixel_t  r;
    int unsigned     sw, sh, tw, th, y0, y1, x0, x1;
    longint unsigned ry, dy, rx, dx, top, bot, num, den;
    sw = (src_w < 1) ? 1 : (src_w > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : src_w;
    sh = (src_h < 1) ? 1 : (src_h > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : src_h;
    tw = (tgt_w > MAX_OUT_DIM) ? MAX_OUT_DIM : tgt_w;
    th = (tgt_h > MAX_OUT_DIM) ? MAX_OUT_DIM : tgt_h;
    if (orow >= th || ocol >= tw) begin
      r.pixel  = '0;
      r.status = 1'b1;
      return r;
    end
    map_coord(orow, sh, th, y0, y1, ry, dy);
    map_coord(ocol, sw, tw, x0, x1, rx, dx);
    top = stored_pixel(y0, x0) * (dx - rx) + stored_pixel(y0, x1) * rx;
    bot = stored_pixel(y1, x0) * (dx - rx) + stored_pixel(y1, x1) * rx;
    num = top * (dy - ry) + bot * ry;
    den = dx * dy;
    r.pixel  = PIX_W'((2 * num + den) / (2 * den));
    r.status = 1'b0;
    return r;
  endfunction

  // Config shadow, input prediction, output compare
  always @(posedge clk_i or negedge rst_ni) begin
    resized_pixel_t want;
    if (!rst_ni) begin
      src_w <= SDIM_W'(256);
      src_h <= SDIM_W'(256);
      tgt_w <= TDIM_W'(256);
      tgt_h <= TDIM_W'(256);
      wide  <= 1'b0;
      expected_pixels.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          IDX_SRC_W: src_w <= pwdata[SDIM_W-1:0];
          IDX_SRC_H: src_h <= pwdata[SDIM_W-1:0];
          IDX_TGT_W: tgt_w <= pwdata[TDIM_W-1:0];
          IDX_TGT_H: tgt_h <= pwdata[TDIM_W-1:0];
          IDX_WIDE:  wide  <= pwdata[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (operation_i == OP_WRITE) begin
          frame_copy[src_row_i * MAX_SRC_WIDTH + src_col_i] = pixel_value_i;
        end else begin
          expected_pixels.push_back(blend_pixel(out_row_i, out_col_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result beat pixel=%h status=%b",
                     result_pixel_i, status_i);
        end else begin
          want = expected_pixels.pop_front();
          if (want.pixel !== result_pixel_i || want.status !== status_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: pixel exp=%h got=%h status exp=%b got=%b",
                       want.pixel, result_pixel_i, want.status, status_i);
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_pixels.size();
    end
  end

endmodule

/* bench/tb_bilinear_image_resize.sv */
module tb_bilinear_image_resize;
  import brz_pkg::*;

  localparam logic [4:0] ADDR_SRC_W = 5'd0;
  localparam logic [4:0] ADDR_SRC_H = 5'd4;
  localparam logic [4:0] ADDR_TGT_W = 5'd8;
  localparam logic [4:0] ADDR_TGT_H = 5'd12;
  localparam logic [4:0] ADDR_WIDE  = 5'd16;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam int SETTLE_CYCLES = 80;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              operation_i = 1'b0;
  logic [SIDX_W-1:0] src_row_i = '0, src_col_i = '0;
  logic [PIX_W-1:0]  pixel_value_i = '0;
  logic [OIDX_W-1:0] out_row_i = '0, out_col_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [PIX_W-1:0]  result_pixel_o;
  logic              status_o;
  int                fail_count, pending;
  int                send_idle_pct = 0, recv_stall_pct = 0;

  bilinear_image_resize dut (.*);

  resize_monitor mon (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .src_row_i, .src_col_i,
    .pixel_value_i, .out_row_i, .out_col_i, .out_valid_i(out_valid_o), .out_ready_i,
    .result_pixel_i(result_pixel_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stalls
  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic apb_write(input logic [4:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_beat(input logic op, input int unsigned srow, input int unsigned scol,
                           input int unsigned pval, input int unsigned orow,
                           input int unsigned ocol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    src_row_i     <= SIDX_W'(srow);
    src_col_i     <= SIDX_W'(scol);
    pixel_value_i <= PIX_W'(pval);
    out_row_i     <= OIDX_W'(orow);
    out_col_i     <= OIDX_W'(ocol);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  // One setting: program, fill the used source region, then resize beats
  task automatic run_phase(input int unsigned sw, input int unsigned sh,
                           input int unsigned tw, input int unsigned th,
                           input logic wide, input int mode, input int n_comp,
                           input bit pause_mid);
    int unsigned esw, esh, etw, eth;
    int unsigned orow, ocol;
    drain_results();
    apb_write(ADDR_SRC_W, sw);
    apb_write(ADDR_SRC_H, sh);
    apb_write(ADDR_TGT_W, tw);
    apb_write(ADDR_TGT_H, th);
    apb_write(ADDR_WIDE, 32'(wide));
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      default: begin send_idle_pct = 34; recv_stall_pct = 34; end
    endcase
    esw = eff_dim(sw, MAX_SRC_WIDTH);
    esh = eff_dim(sh, MAX_SRC_HEIGHT);
    etw = (tw > MAX_OUT_DIM) ? MAX_OUT_DIM : tw;
    eth = (th > MAX_OUT_DIM) ? MAX_OUT_DIM : th;
    for (int r = 0; r < esh; r++)
      for (int c = 0; c < esw; c++)
        send_beat(OP_WRITE, r, c, $urandom, $urandom, $urandom);
    for (int i = 0; i < n_comp; i++) begin
      if (pause_mid && i == n_comp / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      // occasional overwrite anywhere in the store
      if ($urandom_range(9) == 0)
        send_beat(OP_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(99) < 85 && etw > 0 && eth > 0) begin
        orow = $urandom_range(eth - 1);
        ocol = $urandom_range(etw - 1);
      end else begin
        orow = $urandom;
        ocol = $urandom;
      end
      send_beat(OP_COMPUTE, $urandom, $urandom, $urandom, orow, ocol);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 4x3 source to 7x5, 16-bit pixels, extreme values
    apb_write(ADDR_SRC_W, 4);
    apb_write(ADDR_SRC_H, 3);
    apb_write(ADDR_TGT_W, 7);
    apb_write(ADDR_TGT_H, 5);
    apb_write(ADDR_WIDE, 1);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        send_beat(OP_WRITE, r, c, ((r + c) % 2) ? 16'hFFFF : 16'h0000 + 16'h8001 * c,
                  12'hFFF, 12'hFFF);
    send_beat(OP_COMPUTE, 8'hFF, 8'hFF, 16'hFFFF, 0, 0);
    send_beat(OP_COMPUTE, 0, 0, 0, 4, 6);
    send_beat(OP_COMPUTE, 0, 0, 0, 2, 3);
    send_beat(OP_COMPUTE, 0, 0, 0, 1, 5);
    send_beat(OP_COMPUTE, 0, 0, 0, 4, 7);        // column just past target
    send_beat(OP_COMPUTE, 0, 0, 0, 5, 0);        // row just past target
    send_beat(OP_COMPUTE, 0, 0, 0, 12'hFFF, 12'hFFF);
    send_beat(OP_WRITE, 8'hFF, 8'hFF, 16'hA5C3, 0, 0);
    drain_results();
    apb_write(ADDR_WIDE, 0);                     // 8-bit masking on read
    send_beat(OP_COMPUTE, 0, 0, 0, 3, 3);
    send_beat(OP_COMPUTE, 0, 0, 0, 0, 6);

    // Extremes of every register, then small random sizes
    run_phase(256, 1, 4096, 1, 0, 0, 50, 0);
    run_phase(1, 256, 3, 4096, 1, 1, 50, 0);
    run_phase(0, 0, 0, 5, 1, 2, 30, 0);          // zero sizes
    run_phase(511, 1, 8191, 2, 0, 3, 50, 0);     // oversized, clamped
    run_phase(1, 300, 1, 7000, 1, 0, 50, 0);
    for (int p = 0; p < 5; p++)
      run_phase($urandom_range(1, 12), $urandom_range(1, 12),
                ($urandom_range(4) == 0) ? 1 : $urandom_range(1, 40),
                ($urandom_range(4) == 0) ? 1 : $urandom_range(1, 40),
                1'($urandom_range(1)), p % 4, 55, p == 0);

    drain_results();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
